// ===== hdl/irpd_pkg.sv =====
// Package for the IR pulse-distance transmitter: request and result payloads,
// sequencer state, configuration register file types and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned REP_W      = 3;
  localparam int unsigned SYM_W      = 6;
  localparam int unsigned PERIOD_W   = 6;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned PAUSE_W    = 14;
  localparam int unsigned UNITS_W    = 4;
  localparam int unsigned FRAME_W    = 16;

  localparam logic [3:0] MODE_NIBBLE_BASE = 4'h4;
  localparam logic [3:0] CHECK_SEED       = 4'hF;
  localparam logic [3:0] FRAME_LAST_BIT   = 4'd15;
  localparam logic [4:0] FRAME_BITS       = 5'd16;

  localparam logic [UNITS_W-1:0] BASE_UNITS = 4'd5;
  localparam logic [UNITS_W-1:0] LATE_UNITS = 4'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD = 3'd0,
    CFG_PAUSE_UNIT  = 3'd1,
    CFG_MARK        = 3'd2,
    CFG_ZERO_SPACE  = 3'd3,
    CFG_ONE_SPACE   = 3'd4,
    CFG_SS_SPACE    = 3'd5,
    CFG_CHANNEL     = 3'd6,
    CFG_UNUSED      = 3'd7
  } irpd_cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PAUSE = 2'd1,
    PH_MARK  = 2'd2,
    PH_SPACE = 2'd3
  } irpd_phase_e;

  typedef struct packed {
    logic       mode;
    logic [3:0] speed_a;
    logic [3:0] speed_b;
  } irpd_in_t;

  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic rejected;
    logic finished;
  } irpd_out_t;

  typedef struct packed {
    logic [7:0] half_period_ticks;
    logic [9:0] pause_unit_ticks;
    logic [5:0] mark_periods;
    logic [5:0] zero_space_periods;
    logic [5:0] one_space_periods;
    logic [5:0] start_stop_space_periods;
    logic [1:0] channel;
  } irpd_cfg_t;

  typedef struct packed {
    irpd_phase_e         phase;
    logic [REP_W-1:0]    repeat_index;
    logic [SYM_W-1:0]    symbol_index;
    logic [PERIOD_W-1:0] period_count;
    logic [TICK_W-1:0]   tick_count;
    logic [PAUSE_W-1:0]  pause_count;
    logic [FRAME_W-1:0]  frame_word;
    logic                carrier_level;
  } irpd_state_t;

endpackage

// ===== hdl/ir_pulse_distance_transmitter.sv =====
// Top level of the IR pulse-distance transmitter: config registers, sequencer
// state, step logic and result buffer. Depends on irpd_pkg, irpd_step and
// irpd_out_buf.
//
//   channel  signals                           direction
//   in       in_valid_i / in_stall_o / in_req_i     request in
//   out      out_valid_o / out_stall_i / out_res_o  result out
//   cfg      cfg_we_i / cfg_idx_i / cfg_data_i      register write
//
// One request per cycle while in_stall_o is low; step logic is combinational
// from the sequencer state, and the result is valid the cycle after acceptance
// when the output register is free. The two-entry result buffer keeps taking
// requests while one result is stalled; in_stall_o rises only when both entries
// hold results. Reset: sequencer idle, LED off, registers at their reset defaults.
`timescale 1ns / 1ps

module ir_pulse_distance_transmitter #(
  parameter int unsigned REPEATS      = 5,
  parameter int unsigned MESSAGE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  irpd_pkg::irpd_in_t                   in_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output irpd_pkg::irpd_out_t                  out_res_o,
  input  logic                                 cfg_we_i,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import irpd_pkg::*;

  irpd_cfg_t   cfg_q, cfg_d;
  irpd_state_t state_q, state_d;
  irpd_out_t   step_res;
  logic        buf_full;
  logic        in_acc;

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !buf_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (irpd_cfg_idx_e'(cfg_idx_i))
        CFG_HALF_PERIOD: cfg_d.half_period_ticks        = cfg_data_i[7:0];
        CFG_PAUSE_UNIT:  cfg_d.pause_unit_ticks         = cfg_data_i;
        CFG_MARK:        cfg_d.mark_periods             = cfg_data_i[5:0];
        CFG_ZERO_SPACE:  cfg_d.zero_space_periods       = cfg_data_i[5:0];
        CFG_ONE_SPACE:   cfg_d.one_space_periods        = cfg_data_i[5:0];
        CFG_SS_SPACE:    cfg_d.start_stop_space_periods = cfg_data_i[5:0];
        CFG_CHANNEL:     cfg_d.channel                  = cfg_data_i[1:0];
        CFG_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks        <= 8'd13;
      cfg_q.pause_unit_ticks         <= 10'd77;
      cfg_q.mark_periods             <= 6'd6;
      cfg_q.zero_space_periods       <= 6'd10;
      cfg_q.one_space_periods        <= 6'd21;
      cfg_q.start_stop_space_periods <= 6'd39;
      cfg_q.channel                  <= 2'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irpd_step #(
    .REPEATS      (REPEATS),
    .MESSAGE_BITS (MESSAGE_BITS)
  ) u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .req_i   (in_req_i),
    .state_o (state_d),
    .res_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  irpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_data_i (step_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  a_busy_req_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_req_i.mode && state_q.phase != PH_IDLE |=> $stable(state_q))
    else $error("request while busy changed sequencer state");

  a_idle_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_req_i.mode && state_q.phase == PH_IDLE |=> state_q.phase != PH_IDLE)
    else $error("accepted request did not start a transmission");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |-> !state_q.carrier_level && state_q.repeat_index == '0)
    else $error("idle sequencer with live carrier or repeat count");

  a_repeat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.repeat_index < REP_W'(REPEATS))
    else $error("repeat index out of range");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && in_acc |=> out_valid_o)
    else $error("result lost while output stalled");

endmodule

// ===== hdl/irpd_step.sv =====
// Next-state and result logic for one request of the transmitter sequencer.
// Depends on irpd_pkg.
`timescale 1ns / 1ps

module irpd_step #(
  parameter int unsigned REPEATS      = 5,
  parameter int unsigned MESSAGE_BITS = 16
) (
  input  irpd_pkg::irpd_state_t state_i,
  input  irpd_pkg::irpd_cfg_t   cfg_i,
  input  irpd_pkg::irpd_in_t    req_i,
  output irpd_pkg::irpd_state_t state_o,
  output irpd_pkg::irpd_out_t   res_o
);
  import irpd_pkg::*;

  localparam logic [SYM_W-1:0] LAST_DATA_SYM = SYM_W'(MESSAGE_BITS);
  localparam logic [SYM_W-1:0] STOP_SYM      = SYM_W'(MESSAGE_BITS + 1);
  localparam logic [REP_W-1:0] REPEATS_LIM   = REP_W'(REPEATS);

  function automatic logic [PAUSE_W-1:0] pause_len(input logic [REP_W-1:0] rep,
                                                   input logic [1:0] ch,
                                                   input logic [9:0] unit);
    logic [UNITS_W-1:0] units;
    units = '0;
    if (rep == 3'd0) begin
      units = BASE_UNITS - UNITS_W'(ch);
    end else if (rep == 3'd1 || rep == 3'd2) begin
      units = BASE_UNITS;
    end else if (rep == 3'd3 || rep == 3'd4) begin
      units = LATE_UNITS + {1'b0, ch, 1'b0};
    end
    return PAUSE_W'(units) * PAUSE_W'(unit);
  endfunction

  function automatic logic [5:0] at_least_one(input logic [5:0] v);
    return (v == '0) ? 6'd1 : v;
  endfunction

  irpd_state_t        n;
  logic               rejected;
  logic               finished;
  logic [TICK_W:0]    tick_nx;
  logic [TICK_W-1:0]  half_lim;
  logic [PERIOD_W:0]  period_nx;
  logic [5:0]         lim;
  logic [5:0]         space_lim;
  logic [SYM_W-1:0]   bit_pos;
  logic               data_bit;
  logic [SYM_W-1:0]   sym_nx;
  logic [REP_W-1:0]   rep_nx;
  logic [PAUSE_W-1:0] pause_first;
  logic [PAUSE_W-1:0] pause_next;
  logic [3:0]         n1;

  always_comb begin
    bit_pos  = state_i.symbol_index - SYM_W'(1);
    data_bit = 1'b0;
    if (bit_pos < SYM_W'(FRAME_BITS)) begin
      data_bit = state_i.frame_word[FRAME_LAST_BIT - bit_pos[3:0]];
    end
    if (state_i.symbol_index == '0 || state_i.symbol_index > LAST_DATA_SYM) begin
      space_lim = at_least_one(cfg_i.start_stop_space_periods);
    end else if (data_bit) begin
      space_lim = at_least_one(cfg_i.one_space_periods);
    end else begin
      space_lim = at_least_one(cfg_i.zero_space_periods);
    end
    lim = (state_i.phase == PH_MARK) ? at_least_one(cfg_i.mark_periods) : space_lim;
  end

  always_comb begin
    half_lim    = (cfg_i.half_period_ticks == '0) ? TICK_W'(1) : cfg_i.half_period_ticks;
    tick_nx     = {1'b0, state_i.tick_count} + (TICK_W+1)'(1);
    period_nx   = {1'b0, state_i.period_count} + (PERIOD_W+1)'(1);
    sym_nx      = state_i.symbol_index + SYM_W'(1);
    rep_nx      = state_i.repeat_index + REP_W'(1);
    pause_first = pause_len('0, cfg_i.channel, cfg_i.pause_unit_ticks);
    pause_next  = pause_len(rep_nx, cfg_i.channel, cfg_i.pause_unit_ticks);
    n1          = MODE_NIBBLE_BASE | {2'b00, cfg_i.channel};
  end

  always_comb begin
    n        = state_i;
    rejected = 1'b0;
    finished = 1'b0;
    if (req_i.mode) begin
      if (state_i.phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        n.frame_word   = {n1, req_i.speed_b, req_i.speed_a,
                          CHECK_SEED ^ n1 ^ req_i.speed_b ^ req_i.speed_a};
        n.repeat_index = '0;
        n.symbol_index = '0;
        n.pause_count  = pause_first;
        if (pause_first == '0) begin
          n.phase         = PH_MARK;
          n.carrier_level = 1'b1;
          n.tick_count    = '0;
          n.period_count  = '0;
        end else begin
          n.phase = PH_PAUSE;
        end
      end
    end else begin
      unique case (state_i.phase)
        PH_IDLE: begin
        end
        PH_PAUSE: begin
          if (state_i.pause_count <= PAUSE_W'(1)) begin
            n.pause_count   = '0;
            n.phase         = PH_MARK;
            n.carrier_level = 1'b1;
            n.tick_count    = '0;
            n.period_count  = '0;
          end else begin
            n.pause_count = state_i.pause_count - PAUSE_W'(1);
          end
        end
        PH_MARK, PH_SPACE: begin
          n.tick_count = tick_nx[TICK_W-1:0];
          if (tick_nx >= {1'b0, half_lim}) begin
            n.tick_count = '0;
            if (state_i.carrier_level) begin
              n.carrier_level = 1'b0;
            end else begin
              n.carrier_level = 1'b1;
              n.period_count  = period_nx[PERIOD_W-1:0];
              if (period_nx >= {1'b0, lim}) begin
                if (state_i.phase == PH_MARK) begin
                  n.phase        = PH_SPACE;
                  n.period_count = '0;
                end else if (sym_nx > STOP_SYM) begin
                  if (rep_nx >= REPEATS_LIM) begin
                    n.phase         = PH_IDLE;
                    n.symbol_index  = '0;
                    n.period_count  = '0;
                    n.carrier_level = 1'b0;
                    n.repeat_index  = '0;
                    finished        = 1'b1;
                  end else begin
                    n.repeat_index = rep_nx;
                    n.symbol_index = '0;
                    n.pause_count  = pause_next;
                    if (pause_next == '0) begin
                      n.phase        = PH_MARK;
                      n.period_count = '0;
                    end else begin
                      n.phase = PH_PAUSE;
                    end
                  end
                end else begin
                  n.symbol_index = sym_nx;
                  n.phase        = PH_MARK;
                  n.period_count = '0;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign state_o        = n;
  assign res_o.led_on   = (n.phase == PH_MARK) && n.carrier_level;
  assign res_o.busy_res = (n.phase != PH_IDLE);
  assign res_o.rejected = rejected;
  assign res_o.finished = finished;

endmodule

// ===== hdl/irpd_out_buf.sv =====
// Two-entry result buffer: output register plus skid entry, so a request is
// taken while one result waits. Depends on irpd_pkg.
`timescale 1ns / 1ps

module irpd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  irpd_pkg::irpd_out_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output irpd_pkg::irpd_out_t out_res_o
);
  import irpd_pkg::*;

  logic      main_v_q, main_v_d;
  logic      skid_v_q, skid_v_d;
  irpd_out_t main_q, main_d;
  irpd_out_t skid_q, skid_d;
  logic      pop;

  assign pop = main_v_q && !out_stall_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_q || pop) begin
        main_d   = push_data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      main_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_res_o   = main_q;

endmodule
